// File: rtl/core/sopq_pkg.sv
// ----------------------------------------------------------------------------
// sopq_pkg
// Shared sizes, command and status codes and entry type for the sorted
// priority queue.
// ----------------------------------------------------------------------------
package sopq_pkg;

    localparam int DEPTH         = 16;
    localparam int ELEMENT_BITS  = 16;
    localparam int PRIORITY_BITS = 16;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int COUNT_W = 5;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;

    localparam int ENTRY_W = ELEMENT_BITS + PRIORITY_BITS;

    // request payload: element, priority_req, match_priority
    localparam int IN_RAW_W = ELEMENT_BITS + 2 * PRIORITY_BITS;
    localparam int IN_W     = ((IN_RAW_W + 7) / 8) * 8;

    // response payload: status, found, head_valid, head_element, head_priority, count
    localparam int OUT_RAW_W = STAT_W + 2 + ENTRY_W + COUNT_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_INSERT      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE_HEAD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE_EL   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CHANGE      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CONTAINS    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

    typedef struct packed {
        logic [PRIORITY_BITS-1:0] prio;
        logic [ELEMENT_BITS-1:0]  element;
    } entry_t;

endpackage

// File: rtl/core/sopq_ram.sv
// ----------------------------------------------------------------------------
// sopq_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module sopq_ram #(
    parameter int RAM_WIDTH = 32,
    parameter int RAM_DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(RAM_DEPTH)-1:0] waddr,
    input  logic [RAM_WIDTH-1:0]         wdata,
    input  logic                         re,
    input  logic [$clog2(RAM_DEPTH)-1:0] raddr,
    output logic [RAM_WIDTH-1:0]         rdata
);

    logic [RAM_WIDTH-1:0] mem [RAM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Sorted list of (element, priority) entries held in one RAM, kept in
// descending priority order; newer entries go behind older equal ones.
// Each request scans or shifts the list entry by entry as its command needs,
//   then reads the head and loads the response, waiting while output is full.
// One request in flight: the next is accepted once the response is loaded.
// Reset: entry count cleared; RAM contents are left as they are.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import sopq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // element, priority_req, match_priority
    input  logic [CMD_W-1:0] s_tuser,   // cmd
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, found, head_valid, head_element,
                                        // head_priority, count
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_DROP,
        ST_INS_START,
        ST_INS,
        ST_INS_FRONT,
        ST_HEAD,
        ST_HEAD_WAIT
    } state_t;

    state_t                    state_reg,    state_next;
    logic [IDX_W-1:0]          idx_reg,      idx_next;
    logic [CNT_W-1:0]          count_reg,    count_next;
    logic [CMD_W-1:0]          cmd_reg,      cmd_next;
    logic [ELEMENT_BITS-1:0]   el_reg,       el_next;
    logic [PRIORITY_BITS-1:0]  pr_reg,       pr_next;
    logic [PRIORITY_BITS-1:0]  oldp_reg,     oldp_next;
    logic [STAT_W-1:0]         status_reg,   status_next;
    logic                      found_reg,    found_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]          m_tdata_reg,  m_tdata_next;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    entry_t                    ram_wdata;
    logic                      ram_re;
    logic [IDX_W-1:0]          ram_raddr;
    entry_t                    ram_rdata;

    entry_t                    new_entry;
    logic [IDX_W-1:0]          last_idx;
    logic [IDX_W-1:0]          second_last_idx;
    logic                      match;
    logic                      head_valid;
    entry_t                    head;

    sopq_ram #(
        .RAM_WIDTH (ENTRY_W),
        .RAM_DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign new_entry       = '{prio: pr_reg, element: el_reg};
    assign last_idx        = IDX_W'(count_reg - CNT_W'(1));
    assign second_last_idx = IDX_W'(count_reg - CNT_W'(2));
    assign match           = (ram_rdata.element == el_reg) &&
                             ((cmd_reg != CMD_CHANGE) || (ram_rdata.prio == oldp_reg));
    assign head_valid      = (count_reg != '0);
    assign head            = head_valid ? ram_rdata : '0;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        cmd_next      = cmd_reg;
        el_next       = el_reg;
        pr_next       = pr_reg;
        oldp_next     = oldp_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = new_entry;
        ram_re        = 1'b0;
        ram_raddr     = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next    = s_tuser;
                    el_next     = s_tdata[ELEMENT_BITS-1:0];
                    pr_next     = s_tdata[ELEMENT_BITS +: PRIORITY_BITS];
                    oldp_next   = s_tdata[ELEMENT_BITS + PRIORITY_BITS +: PRIORITY_BITS];
                    status_next = STAT_OK;
                    found_next  = 1'b0;
                    state_next  = ST_HEAD;
                    case (s_tuser)
                        CMD_INSERT:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                state_next = ST_INS_START;
                            end
                        end
                        CMD_REMOVE_HEAD:
                        begin
                            if (count_reg == CNT_W'(1))
                            begin
                                count_next = '0;
                            end
                            else if (count_reg != '0)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = IDX_W'(1);
                                idx_next   = '0;
                                state_next = ST_DROP;
                            end
                        end
                        CMD_REMOVE_EL, CMD_CHANGE, CMD_CONTAINS:
                        begin
                            if (count_reg == '0)
                            begin
                                if (s_tuser != CMD_CONTAINS)
                                begin
                                    status_next = STAT_NOT_FOUND;
                                end
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                idx_next   = '0;
                                state_next = ST_FIND;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_HEAD;
                        end
                    endcase
                end
            end

            // ram_rdata holds entry idx_reg
            ST_FIND:
            begin
                if (match)
                begin
                    if (cmd_reg == CMD_CONTAINS)
                    begin
                        found_next = 1'b1;
                        state_next = ST_HEAD;
                    end
                    else if (idx_reg == last_idx)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = (cmd_reg == CMD_CHANGE) ? ST_INS_START : ST_HEAD;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = idx_reg + IDX_W'(1);
                        state_next = ST_DROP;
                    end
                end
                else if (idx_reg == last_idx)
                begin
                    if (cmd_reg != CMD_CONTAINS)
                    begin
                        status_next = STAT_NOT_FOUND;
                    end
                    state_next = ST_HEAD;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + IDX_W'(1);
                    idx_next  = idx_reg + IDX_W'(1);
                end
            end

            // close the gap: ram_rdata holds entry idx_reg + 1
            ST_DROP:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                if (idx_reg == second_last_idx)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = (cmd_reg == CMD_CHANGE) ? ST_INS_START : ST_HEAD;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + IDX_W'(2);
                    idx_next  = idx_reg + IDX_W'(1);
                end
            end

            ST_INS_START:
            begin
                if (count_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    count_next = CNT_W'(1);
                    state_next = ST_HEAD;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = last_idx;
                    idx_next   = last_idx;
                    state_next = ST_INS;
                end
            end

            // walk from the tail, shifting lower-priority entries back by one
            ST_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg + IDX_W'(1);
                if (ram_rdata.prio >= pr_reg)
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_HEAD;
                end
                else
                begin
                    ram_wdata = ram_rdata;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_INS_FRONT;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg - IDX_W'(1);
                        idx_next  = idx_reg - IDX_W'(1);
                    end
                end
            end

            ST_INS_FRONT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_HEAD;
            end

            ST_HEAD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_next = ST_HEAD_WAIT;
            end

            ST_HEAD_WAIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({COUNT_W'(count_reg), head.prio, head.element,
                                            head_valid, found_reg, status_reg});
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            count_reg    <= '0;
            cmd_reg      <= CMD_INSERT;
            el_reg       <= '0;
            pr_reg       <= '0;
            oldp_reg     <= '0;
            status_reg   <= STAT_OK;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            count_reg    <= count_next;
            cmd_reg      <= cmd_next;
            el_reg       <= el_next;
            pr_reg       <= pr_next;
            oldp_reg     <= oldp_next;
            status_reg   <= status_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted request not processed");

    a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (CNT_W'(ram_waddr) <= count_reg))
        else $error("RAM write beyond end of list");

    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |->
            (m_tdata_reg[STAT_W + 1] == (m_tdata_reg[OUT_RAW_W-1 -: COUNT_W] != '0)))
        else $error("head_valid disagrees with count");
`endif

endmodule

// File: test/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Drives insert, remove, change, contains and clear requests into the sorted
// priority queue and checks every response against a behavioral copy of the
// queue kept here. Runs directed corner cases, a long output stall and inserts
// that fill the queue, then random traffic under several idle patterns.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
    import sopq_pkg::*;

    // codes the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

    localparam int DRAIN_CYCLES = 2 * DEPTH + 12;

    // m_tdata layout, msb first, so a plain assignment unpacks it
    typedef struct packed {
        logic [COUNT_W-1:0]       count;
        logic [PRIORITY_BITS-1:0] head_priority;
        logic [ELEMENT_BITS-1:0]  head_element;
        logic                     head_valid;
        logic                     found;
        logic [STAT_W-1:0]        status;
    } response_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;   // element, priority_req, match_priority
    logic [CMD_W-1:0] s_tuser;   // cmd
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;   // status, found, head_valid, head_element,
                                 // head_priority, count

    entry_t    model_entries [DEPTH];
    int        model_count;
    response_t pending_results [$];

    int error_count;
    int mismatch_count;
    int sender_idle_pct;
    int recv_idle_pct;
    int hold_left;

    sorted_priority_queue u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("sorted_priority_queue verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Queue model
    // ------------------------------------------------------------------------
    function automatic void drop_entry(input int pos);
        int i;
        for (i = pos; i + 1 < model_count; i++)
            model_entries[i] = model_entries[i + 1];
        model_count--;
    endfunction

    // new entry goes behind all entries of equal or higher priority
    function automatic void insert_entry(input logic [ELEMENT_BITS-1:0] el,
                                         input logic [PRIORITY_BITS-1:0] pr);
        int pos;
        int i;
        pos = 0;
        while (pos < model_count && model_entries[pos].prio >= pr)
            pos++;
        for (i = model_count; i > pos; i--)
            model_entries[i] = model_entries[i - 1];
        model_entries[pos].prio    = pr;
        model_entries[pos].element = el;
        model_count++;
    endfunction

    function automatic response_t apply_request(input logic [CMD_W-1:0] cmd,
                                                input logic [ELEMENT_BITS-1:0] el,
                                                input logic [PRIORITY_BITS-1:0] pr,
                                                input logic [PRIORITY_BITS-1:0] op);
        response_t r;
        int        hit;
        int        i;
        r   = '0;
        hit = -1;
        r.status = STAT_OK;
        case (cmd)
            CMD_INSERT:
            begin
                if (model_count >= DEPTH)
                    r.status = STAT_FULL;
                else
                    insert_entry(el, pr);
            end
            CMD_REMOVE_HEAD:
            begin
                if (model_count > 0)
                    drop_entry(0);
            end
            CMD_REMOVE_EL:
            begin
                for (i = 0; i < model_count; i++)
                    if (hit < 0 && model_entries[i].element == el)
                        hit = i;
                if (hit >= 0)
                    drop_entry(hit);
                else
                    r.status = STAT_NOT_FOUND;
            end
            CMD_CHANGE:
            begin
                for (i = 0; i < model_count; i++)
                    if (hit < 0 && model_entries[i].element == el &&
                        model_entries[i].prio == op)
                        hit = i;
                if (hit >= 0)
                begin
                    drop_entry(hit);
                    insert_entry(el, pr);
                end
                else
                    r.status = STAT_NOT_FOUND;
            end
            CMD_CONTAINS:
            begin
                for (i = 0; i < model_count; i++)
                    if (model_entries[i].element == el)
                        r.found = 1'b1;
            end
            CMD_CLEAR:
                model_count = 0;
            default: ;
        endcase
        if (model_count > 0)
        begin
            r.head_valid    = 1'b1;
            r.head_element  = model_entries[0].element;
            r.head_priority = model_entries[0].prio;
        end
        r.count = model_count[COUNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: changes at the falling edge, handshake seen at rising
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [ELEMENT_BITS-1:0] el,
                                input logic [PRIORITY_BITS-1:0] pr,
                                input logic [PRIORITY_BITS-1:0] op);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {op, pr, el};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(apply_request(cmd, el, pr, op));
        @(negedge clk);
    endtask

    // receiver: long hold-off when asked, random stalls otherwise
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else
                m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_responses
        response_t got;
        response_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[OUT_RAW_W-1:0];
            if (pending_results.size() == 0)
            begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: response with no request pending: %h", $realtime, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got != want)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch exp st=%0d fnd=%0b hv=%0b el=%h pr=%h cnt=%0d",
                                 $realtime, want.status, want.found, want.head_valid,
                                 want.head_element, want.head_priority, want.count,
                                 " | got st=%0d fnd=%0b hv=%0b el=%h pr=%h cnt=%0d",
                                 got.status, got.found, got.head_valid,
                                 got.head_element, got.head_priority, got.count);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_empty_queue();
        send_request(CMD_REMOVE_HEAD, 16'h0000, 16'h0000, 16'h0000);
        send_request(CMD_REMOVE_EL,   16'hFFFF, 16'h0000, 16'h0000);
        send_request(CMD_CHANGE,      16'h0000, 16'hFFFF, 16'h0000);
        send_request(CMD_CONTAINS,    16'h0000, 16'h0000, 16'h0000);
        send_request(CMD_UNUSED_A,    16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(CMD_UNUSED_B,    16'hA5A5, 16'h5A5A, 16'hFFFF);
    endtask

    task automatic test_order_and_lookup();
        send_request(CMD_INSERT,   16'h0000, 16'h0000, 16'hFFFF);
        send_request(CMD_INSERT,   16'hFFFF, 16'hFFFF, 16'h0000);
        send_request(CMD_INSERT,   16'h1234, 16'h8000, 16'h0000);
        // equal priority lands behind the older entry
        send_request(CMD_INSERT,   16'h5678, 16'h8000, 16'h0000);
        send_request(CMD_INSERT,   16'h1234, 16'h7FFF, 16'h0000);
        send_request(CMD_UNUSED_A, 16'h0000, 16'h0000, 16'h0000);
        send_request(CMD_CONTAINS, 16'h5678, 16'h0000, 16'h0000);
        send_request(CMD_CONTAINS, 16'h9999, 16'h0000, 16'h0000);
        send_request(CMD_REMOVE_EL, 16'h1234, 16'h0000, 16'h0000);
        // old priority wrong: not found
        send_request(CMD_CHANGE,   16'h5678, 16'h0001, 16'h7FFF);
        // moves behind the existing 0xFFFF entry
        send_request(CMD_CHANGE,   16'h5678, 16'hFFFF, 16'h8000);
        send_request(CMD_REMOVE_HEAD, 16'h0000, 16'h0000, 16'h0000);
        send_request(CMD_CLEAR,    16'h0000, 16'h0000, 16'h0000);
        send_request(CMD_REMOVE_HEAD, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // output held off, so requests wait; then the queue fills, insert sees full
    task automatic test_full_backpressure();
        int k;
        @(negedge clk);
        hold_left = 300;
        for (k = 0; k <= DEPTH; k++)
            send_request(CMD_INSERT, 16'(k * 3), 16'(k % 4), 16'h0000);
        send_request(CMD_CHANGE,    16'h0003, 16'h0003, 16'h0001);
        send_request(CMD_REMOVE_EL, 16'h0000, 16'h0000, 16'h0000);
        send_request(CMD_INSERT,    16'hBEEF, 16'hFFFF, 16'h0000);
        send_request(CMD_INSERT,    16'hDEAD, 16'h0000, 16'h0000);
    endtask

    function automatic logic [PRIORITY_BITS-1:0] random_priority();
        case ($urandom_range(0, 9))
            0, 1, 2, 3:    return PRIORITY_BITS'($urandom);
            8:             return '1;
            9:             return 16'h8000;
            default:       return PRIORITY_BITS'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic test_random_mix(input int n_items);
        int                       k;
        int                       r;
        int                       pick;
        logic [CMD_W-1:0]         cmd;
        logic [ELEMENT_BITS-1:0]  el;
        logic [PRIORITY_BITS-1:0] pr;
        logic [PRIORITY_BITS-1:0] op;
        for (k = 0; k < n_items; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)      cmd = CMD_INSERT;
            else if (r < 55) cmd = CMD_REMOVE_HEAD;
            else if (r < 67) cmd = CMD_REMOVE_EL;
            else if (r < 81) cmd = CMD_CHANGE;
            else if (r < 93) cmd = CMD_CONTAINS;
            else if (r < 96) cmd = CMD_CLEAR;
            else if (r < 98) cmd = CMD_UNUSED_A;
            else             cmd = CMD_UNUSED_B;
            if ($urandom_range(0, 3) == 0)
                el = ELEMENT_BITS'($urandom);
            else
                el = ELEMENT_BITS'($urandom_range(0, 7));
            pr = random_priority();
            op = random_priority();
            // mostly aim lookups at entries that are really held
            if ((cmd == CMD_CHANGE || cmd == CMD_REMOVE_EL || cmd == CMD_CONTAINS) &&
                model_count > 0 && $urandom_range(0, 3) != 0)
            begin
                pick = $urandom_range(0, model_count - 1);
                el   = model_entries[pick].element;
                op   = model_entries[pick].prio;
            end
            send_request(cmd, el, pr, op);
        end
    endtask

    initial
    begin
        int guard;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = CMD_INSERT;
        rst_n           = 1'b0;
        model_count     = 0;
        error_count     = 0;
        mismatch_count  = 0;
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        hold_left       = 0;
        guard           = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sender_idle_pct = 6;
        recv_idle_pct   = 45;
        test_empty_queue();
        test_order_and_lookup();
        test_full_backpressure();
        test_random_mix(180);

        sender_idle_pct = 45;
        recv_idle_pct   = 6;
        test_random_mix(180);

        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        test_random_mix(200);

        s_tvalid = 1'b0;
        while (pending_results.size() != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        error_count += pending_results.size();
        if (error_count == 0)
            $display("sorted_priority_queue verification clean");
        else
            $display("sorted_priority_queue verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/sopq_pkg.sv
rtl/core/sopq_ram.sv
rtl/core/sorted_priority_queue.sv
test/sorted_priority_queue_tb.sv
